// ===== design/pool_pkg.sv =====
// pool_pkg: shared types and constants for the pooling engine.
// No dependencies.
package pool_pkg;

    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_BITS  = 7;
    localparam int IDX_BITS  = 3;

    localparam logic [2:0] REG_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_WIN_ROWS = 3'd2;
    localparam logic [2:0] REG_WIN_COLS = 3'd3;
    localparam logic [2:0] REG_PAD_ROWS = 3'd4;
    localparam logic [2:0] REG_PAD_COLS = 3'd5;
    localparam logic [2:0] REG_STEP_ROWS = 3'd6;
    localparam logic [2:0] REG_STEP_COLS = 3'd7;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_MAX   = 2'd1;
    localparam logic [1:0] ACT_AVG   = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] value;
        logic [11:0]        max_index;
    } out_word_t;

endpackage

// ===== design/pooling_forward_max_avg_top.sv =====
// Pooling engine top level: plane memory, window scan sequencer, divider.
// Depends on pool_pkg.
//
// One command per busy period; busy rises the cycle after start and the result
// strobe comes once, with busy falling in the same cycle, so a new word can be
// taken in the strobe cycle. A write is done in the grid row state and then goes
// to the done state. A query loads and tests the row span, checks the column, sets
// up the window, reads one in-plane window sample per cycle from the single memory
// read port and drains the read pipeline; it then loads the result, for averages
// after a restoring division over sample width plus 16 quotient bits. Empty windows
// go from the window setup straight to the done state. The receiver cannot stall.
module pooling_forward_max_avg_top #(
    parameter int MAX_HEIGHT  = pool_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH   = pool_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = pool_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  pool_pkg::in_word_t          cmd,
    output logic                        busy,
    output logic                        result_strobe,
    output pool_pkg::out_word_t         result,
    input  logic                        cfg_we,
    input  logic [pool_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [pool_pkg::CFG_BITS-1:0] cfg_data
);
    localparam int HB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AB = HB + WB;
    localparam int DEPTH = 1 << AB;
    localparam int SB = SAMPLE_BITS;
    localparam int CW = 16;   // signed coordinate width
    localparam int SUMW = SB + 16;
    localparam int DCNT = 6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GRIDR = 4'd1;
    localparam logic [3:0] S_GRIDC = 4'd2;
    localparam logic [3:0] S_WIN   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [6:0] hgt_cfg_reg, wid_cfg_reg, kh_reg, kw_reg, sh_reg, sw_reg;
    logic [5:0] ph_reg, pw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hgt_cfg_reg <= 7'd8;
            wid_cfg_reg <= 7'd8;
            kh_reg      <= 7'd2;
            kw_reg      <= 7'd2;
            ph_reg      <= 6'd0;
            pw_reg      <= 6'd0;
            sh_reg      <= 7'd2;
            sw_reg      <= 7'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pool_pkg::REG_HEIGHT:    hgt_cfg_reg <= cfg_data;
                pool_pkg::REG_WIDTH:     wid_cfg_reg <= cfg_data;
                pool_pkg::REG_WIN_ROWS:  kh_reg      <= cfg_data;
                pool_pkg::REG_WIN_COLS:  kw_reg      <= cfg_data;
                pool_pkg::REG_PAD_ROWS:  ph_reg      <= cfg_data[5:0];
                pool_pkg::REG_PAD_COLS:  pw_reg      <= cfg_data[5:0];
                pool_pkg::REG_STEP_ROWS: sh_reg      <= cfg_data;
                pool_pkg::REG_STEP_COLS: sw_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated plane size
    logic signed [CW-1:0] hgt, wid;
    assign hgt = (int'(hgt_cfg_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(hgt_cfg_reg);
    assign wid = (int'(wid_cfg_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(wid_cfg_reg);

    // plane memory
    logic [SB-1:0] mem [DEPTH];
    logic          mem_we;
    logic [AB-1:0] mem_waddr, mem_raddr;
    logic [SB-1:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    logic [3:0] state_reg, state_next;
    pool_pkg::in_word_t cmd_reg;

    // grid check: row * stride against the span, rows then columns
    logic signed [CW-1:0] span_reg, span_next;
    logic [6:0] cnt_reg, cnt_next;

    logic signed [CW-1:0] h0_reg, h1_reg, w0_reg, w1_reg, h_reg, w_reg;
    logic signed [CW-1:0] h0_next, h1_next, w0_next, w1_next, h_next, w_next;
    logic signed [CW-1:0] area_reg, area_next;
    logic scan_v_reg, scan_v_next;
    logic [11:0] rd_idx_reg;
    logic signed [SB-1:0] best_reg, best_next;
    logic [11:0] bi_reg, bi_next;
    logic first_reg, first_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;

    // divider
    logic [SUMW-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [DCNT-1:0] dcnt_reg, dcnt_next;
    logic neg_reg, neg_next;

    pool_pkg::out_word_t res_reg, res_next;
    logic strobe_reg, strobe_next;

    logic signed [CW-1:0] kh_s, kw_s, ph_s, pw_s, sh_s, sw_s, row_s, col_s;
    assign kh_s = CW'(kh_reg);
    assign kw_s = CW'(kw_reg);
    assign ph_s = CW'(ph_reg);
    assign pw_s = CW'(pw_reg);
    assign sh_s = CW'(sh_reg);
    assign sw_s = CW'(sw_reg);
    assign row_s = CW'(cmd_reg.row);
    assign col_s = CW'(cmd_reg.col);

    logic signed [CW-1:0] prod_r, prod_c;
    assign prod_r = CW'(cmd_reg.row) * sh_s;
    assign prod_c = CW'(cmd_reg.col) * sw_s;

    logic signed [SB-1:0] rd_s;
    assign rd_s = mem_rdata_reg;
    logic [SUMW:0] rem_sh, rem_try;
    assign rem_sh  = {rem_reg[SUMW-1:0], quo_reg[SUMW-1]};
    assign rem_try = rem_sh - (SUMW+1)'(unsigned'(area_reg));

    always_comb
    begin
        state_next  = state_reg;
        span_next   = span_reg;
        cnt_next    = cnt_reg;
        h0_next = h0_reg; h1_next = h1_reg; w0_next = w0_reg; w1_next = w1_reg;
        h_next = h_reg; w_next = w_reg;
        area_next   = area_reg;
        scan_v_next = 1'b0;
        best_next   = best_reg;
        bi_next     = bi_reg;
        first_next  = first_reg;
        sum_next    = sum_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = SB'(cmd_reg.sample);
        mem_raddr   = {h_reg[HB-1:0], w_reg[WB-1:0]};
        mem_waddr   = {HB'(cmd_reg.row), WB'(cmd_reg.col)};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_GRIDR;
            end
            S_GRIDR:
            begin
                res_next = '0;
                if (cmd_reg.action == pool_pkg::ACT_WRITE)
                begin
                    if (row_s < hgt && col_s < wid)
                    begin
                        mem_we = 1'b1;
                        res_next.status = pool_pkg::ST_WRITTEN;
                    end
                    else
                        res_next.status = pool_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else if (cmd_reg.action != pool_pkg::ACT_MAX
                         && cmd_reg.action != pool_pkg::ACT_AVG)
                begin
                    res_next.status = pool_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else if (cnt_reg == 7'd0)
                begin
                    // first visit: load row span
                    span_next = hgt + (ph_s <<< 1) - kh_s;
                    cnt_next  = 7'd1;
                end
                else
                begin
                    // row index fits if row*step <= span (step 0: row 0 only)
                    if (sh_reg == 7'd0 ? (cmd_reg.row != 6'd0)
                        : (span_reg < 0 || prod_r > span_reg))
                    begin
                        res_next.status = pool_pkg::ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        span_next  = wid + (pw_s <<< 1) - kw_s;
                        state_next = S_GRIDC;
                    end
                    cnt_next = 7'd0;
                end
            end
            S_GRIDC:
            begin
                if (sw_reg == 7'd0 ? (cmd_reg.col != 6'd0)
                    : (span_reg < 0 || prod_c > span_reg))
                begin
                    res_next.status = pool_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    h0_next = prod_r - ph_s;
                    w0_next = prod_c - pw_s;
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                if (cmd_reg.action == pool_pkg::ACT_MAX)
                begin
                    h1_next = (h0_reg + kh_s < hgt) ? h0_reg + kh_s : hgt;
                    w1_next = (w0_reg + kw_s < wid) ? w0_reg + kw_s : wid;
                    area_next = '0;
                end
                else
                begin
                    h1_next = (h0_reg + kh_s < hgt + ph_s) ? h0_reg + kh_s : hgt + ph_s;
                    w1_next = (w0_reg + kw_s < wid + pw_s) ? w0_reg + kw_s : wid + pw_s;
                    area_next = CW'((h1_next - h0_reg) * (w1_next - w0_reg));
                    if (h1_next > hgt) h1_next = hgt;
                    if (w1_next > wid) w1_next = wid;
                end
                if (h0_reg < 0) h0_next = '0;
                if (w0_reg < 0) w0_next = '0;
                h_next = h0_next;
                w_next = w0_next;
                first_next = 1'b1;
                sum_next = '0;
                if (h0_next >= h1_next || w0_next >= w1_next
                    || (cmd_reg.action == pool_pkg::ACT_AVG && area_next <= 0))
                begin
                    res_next.status = pool_pkg::ST_EMPTY;
                    res_next.value = (cmd_reg.action == pool_pkg::ACT_MAX)
                        ? 16'($signed({1'b1, {(SB-1){1'b0}}})) : 16'sd0;
                    state_next = S_DONE;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                scan_v_next = 1'b1;
                if (w_reg + CW'(1) < w1_reg)
                    w_next = w_reg + CW'(1);
                else
                begin
                    w_next = w0_reg;
                    h_next = h_reg + CW'(1);
                    if (h_reg + CW'(1) >= h1_reg)
                        state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!scan_v_reg)
                begin
                    if (cmd_reg.action == pool_pkg::ACT_MAX)
                    begin
                        res_next.status = pool_pkg::ST_OK;
                        res_next.value = 16'(best_reg);
                        res_next.max_index = bi_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        neg_next = sum_reg < 0;
                        quo_next = sum_reg < 0 ? SUMW'(-sum_reg) : SUMW'(sum_reg);
                        rem_next = '0;
                        dcnt_next = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (rem_try[SUMW])
                    rem_next = rem_sh[SUMW-1:0];
                else
                    rem_next = rem_try[SUMW-1:0];
                quo_next = {quo_reg[SUMW-2:0], ~rem_try[SUMW]};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT'(SUMW-1))
                    state_next = S_DONE;
                if (dcnt_reg == DCNT'(SUMW-1))
                begin
                    res_next.status = pool_pkg::ST_OK;
                    res_next.value = neg_reg ? 16'(-quo_next) : 16'(quo_next);
                end
            end
            S_DONE:
            begin
                strobe_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // accumulate the registered read data
        if (scan_v_reg)
        begin
            sum_next = sum_reg + SUMW'(rd_s);
            if (first_reg || rd_s > best_reg)
            begin
                best_next = rd_s;
                bi_next = rd_idx_reg;
            end
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            scan_v_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            scan_v_reg <= scan_v_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
        span_reg <= span_next;
        h0_reg <= h0_next; h1_reg <= h1_next; w0_reg <= w0_next; w1_reg <= w1_next;
        h_reg <= h_next; w_reg <= w_next;
        area_reg <= area_next;
        best_reg <= best_next;
        bi_reg <= bi_next;
        first_reg <= first_next;
        sum_reg <= sum_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        rd_idx_reg <= 12'(h_reg * wid + w_reg);
    end

    assign busy = state_reg != S_IDLE;
    assign result_strobe = strobe_reg;
    assign result = res_reg;
endmodule

// ===== design/pool_checker.sv =====
// pool_checker: port-level checks on the pooling engine top level.
// Depends on pool_pkg; bound to pooling_forward_max_avg_top.
module pool_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_strobe,
    input pool_pkg::out_word_t result
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> !busy) else $error("busy during strobe");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe) else $error("double strobe");
    a_idx_max_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status != pool_pkg::ST_OK |-> result.max_index == 12'd0)
        else $error("stray index");
endmodule

bind pooling_forward_max_avg_top pool_checker u_pool_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_strobe(result_strobe), .result(result)
);
